FILE: sv/fsba_pkg.sv
// ----------------------------------------------------------------------------
// fsba_pkg
// Shared types and constants of the fixed slot buffer allocator: status codes,
// command codes and the width of one free map word.
// ----------------------------------------------------------------------------
package fsba_pkg;

	// Slots held in one word of the free map memory.
	localparam int unsigned WORD_W = 32;
	localparam int unsigned BIT_W  = 5;

	// Command carried with each request item.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status returned with each result item.
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_EMPTY        = 2'd1,
		ST_UNKNOWN      = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

endpackage

FILE: sv/fsba_ram.sv
// ----------------------------------------------------------------------------
// fsba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/fixed_slot_buffer_allocator.sv
// ----------------------------------------------------------------------------
// fixed_slot_buffer_allocator
// Pool of equal-size slots tracked by a free map in RAM and a free counter.
// Allocate grants the lowest free slot; free returns a slot to the pool.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Signals                       | Content
//  ---------+-----------+-------------------------------+------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata     | request item
//           |           | s_tuser                       |
//  m_*      | out       | m_tvalid m_tready m_tdata     | result item
//           |           | m_tuser                       |
//  cfg_*    | in        | cfg_valid cfg_ready cfg_data  | slot_count register
//
// An allocate steps through accept, RAM read, evaluate and write back with
// the result, and repeats the read and evaluate steps for each further
// 32-slot word of the free map that it has to scan. A free of a slot in the
// pool takes accept, read, evaluate and write back; a free of a slot outside
// the pool skips the RAM and goes from accept to write back. Reset and a
// slot_count write free every slot at once through per-word valid flags, so
// no clearing pass is needed. A result still held at the output stalls the
// write-back step of the next request; a new request is accepted meanwhile.
// ----------------------------------------------------------------------------
module fixed_slot_buffer_allocator #(
	parameter int unsigned MAX_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request: tdata = slot_index[5:0]; tuser = cmd[0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	// Result: tdata = granted_slot[5:0], free_slots[12:6]; tuser = status[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	// Configuration: slot_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	localparam int unsigned ROWS    = (MAX_SLOTS + fsba_pkg::WORD_W - 1) / fsba_pkg::WORD_W;
	localparam int unsigned ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned SLOT_W  = ROW_AW + fsba_pkg::BIT_W;
	localparam int unsigned CMP_W   = (SLOT_W > 7) ? SLOT_W : 7;
	localparam int unsigned RST_CNT = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_EVAL,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic                           cmd_q;
	logic [fsba_pkg::BIT_W-1:0]     idx_q;
	logic [ROW_AW-1:0]              row_q;
	logic [ROWS-1:0]                row_valid_q;
	logic                           valid_s1;
	logic [6:0]                     slot_count_q;
	logic [6:0]                     free_total_q;
	logic [fsba_pkg::WORD_W-1:0]    wr_data_q;
	logic                           wr_pend_q;
	fsba_pkg::status_t              status_q;
	logic [5:0]                     granted_q;
	logic                           dec_q;
	logic                           inc_q;
	fsba_pkg::status_t              out_status_q;
	logic [5:0]                     out_granted_q;
	logic [6:0]                     out_free_q;
	logic                           out_valid_q;

	logic [fsba_pkg::WORD_W-1:0]    rd_data;
	logic [fsba_pkg::WORD_W-1:0]    word;
	logic [fsba_pkg::WORD_W-1:0]    in_range;
	logic [fsba_pkg::WORD_W-1:0]    avail;
	logic [fsba_pkg::BIT_W-1:0]     low_bit;
	logic                           any_avail;
	logic [6:0]                     last_row;
	logic [6:0]                     cfg_count;
	logic                           out_free_slot;
	logic                           wr_en;
	logic                           rd_en;
	logic [SLOT_W-1:0]              grant_slot;
	logic [fsba_pkg::BIT_W-1:0]     free_bit;
	logic [6:0]                     free_total_dec;
	logic [6:0]                     free_total_inc;

	// Free map storage, one bit per slot, 32 slots per word.
	fsba_ram #(
		.WIDTH (fsba_pkg::WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_q),
		.wr_data (wr_data_q),
		.rd_en   (rd_en),
		.rd_addr (row_q),
		.rd_data (rd_data)
	);

	// Handshakes and result packing.
	assign s_tready      = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = {3'b000, out_free_q, out_granted_q};
	assign m_tuser       = out_status_q;
	assign out_free_slot = !out_valid_q || m_tready;
	assign rd_en         = (state_q == S_ISSUE);
	assign wr_en         = (state_q == S_DONE) && out_free_slot && wr_pend_q;

	// A word never written since the last pool reset reads as all free.
	assign word = valid_s1 ? rd_data : '1;

	// Slots of the current word that lie below the slot count.
	always_comb begin
		for (int b = 0; b < fsba_pkg::WORD_W; b++) begin
			in_range[b] = CMP_W'({row_q, fsba_pkg::BIT_W'(b)}) < CMP_W'(slot_count_q);
		end
	end
	assign avail = word & in_range;

	// Lowest free slot in the word.
	always_comb begin
		low_bit = '0;
		for (int b = fsba_pkg::WORD_W - 1; b >= 0; b--) begin
			if (avail[b]) begin
				low_bit = fsba_pkg::BIT_W'(b);
			end
		end
	end
	assign any_avail  = |avail;
	assign grant_slot = {row_q, low_bit};
	assign last_row   = (slot_count_q - 7'd1) >> fsba_pkg::BIT_W;
	assign free_bit   = idx_q[fsba_pkg::BIT_W-1:0];

	// Counter updates with their limits.
	assign free_total_dec = (free_total_q != 7'd0) ? free_total_q - 7'd1 : free_total_q;
	assign free_total_inc = (free_total_q < slot_count_q) ? free_total_q + 7'd1 : free_total_q;

	// Written slot count: zero becomes one, above the pool size saturates.
	always_comb begin
		cfg_count = cfg_data;
		if (cfg_data == 7'd0) begin
			cfg_count = 7'd1;
		end else if (32'(cfg_data) > MAX_SLOTS) begin
			cfg_count = 7'(MAX_SLOTS);
		end
	end

	// Request sequencer with the pool state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_valid_q  <= '0;
			slot_count_q <= 7'(RST_CNT);
			free_total_q <= 7'(RST_CNT);
			wr_pend_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// The result leaves at its handshake unless a new one is loaded.
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				slot_count_q <= cfg_count;
				free_total_q <= cfg_count;
				row_valid_q  <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q     <= s_tuser[0];
						idx_q     <= s_tdata[fsba_pkg::BIT_W-1:0];
						wr_pend_q <= 1'b0;
						dec_q     <= 1'b0;
						inc_q     <= 1'b0;
						granted_q <= '0;
						if (s_tuser[0] == fsba_pkg::CMD_ALLOC) begin
							row_q   <= '0;
							state_q <= S_ISSUE;
						end else if (7'(s_tdata[5:0]) >= slot_count_q) begin
							status_q <= fsba_pkg::ST_UNKNOWN;
							state_q  <= S_DONE;
						end else begin
							row_q   <= ROW_AW'(s_tdata[5:0] >> fsba_pkg::BIT_W);
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					valid_s1 <= row_valid_q[row_q];
					state_q  <= S_EVAL;
				end
				S_EVAL: begin
					if (cmd_q == fsba_pkg::CMD_ALLOC) begin
						if (any_avail) begin
							wr_data_q <= word & ~(fsba_pkg::WORD_W'(1) << low_bit);
							wr_pend_q <= 1'b1;
							dec_q     <= 1'b1;
							granted_q <= grant_slot[5:0];
							status_q  <= fsba_pkg::ST_OK;
							state_q   <= S_DONE;
						end else if (7'(row_q) == last_row) begin
							status_q <= fsba_pkg::ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							row_q   <= row_q + ROW_AW'(1);
							state_q <= S_ISSUE;
						end
					end else begin
						if (word[free_bit]) begin
							status_q <= fsba_pkg::ST_ALREADY_FREE;
						end else begin
							wr_data_q <= word | (fsba_pkg::WORD_W'(1) << free_bit);
							wr_pend_q <= 1'b1;
							inc_q     <= 1'b1;
							status_q  <= fsba_pkg::ST_OK;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free_slot) begin
						if (wr_pend_q) begin
							row_valid_q[row_q] <= 1'b1;
						end
						if (dec_q) begin
							free_total_q <= free_total_dec;
							out_free_q   <= free_total_dec;
						end else if (inc_q) begin
							free_total_q <= free_total_inc;
							out_free_q   <= free_total_inc;
						end else begin
							out_free_q <= free_total_q;
						end
						out_status_q  <= status_q;
						out_granted_q <= granted_q;
						out_valid_q   <= 1'b1;
						wr_pend_q     <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the fixed slot buffer allocator. A slot pool
// tracker follows every accepted request and every slot_count write, and
// queues the reply it predicts. Each reply leaving the block is checked field
// by field against the oldest queued one. A directed opening covers the
// corner cases, and random phases with mixed pool sizes and idling follow.
// ----------------------------------------------------------------------------
module testbench;

	// Expected reply of one request item.
	typedef struct {
		fsba_pkg::status_t status;
		logic [5:0]        granted;
		logic [6:0]        free_slots;
	} reply_t;

	// Tracks the free map and free count and predicts the reply of each request.
	class slot_pool_model;
		bit [63:0]   free_map;
		int unsigned free_total;
		int unsigned slot_count;
		reply_t      awaited[$];
		int unsigned failures;

		function new();
			slot_count = 64;
			failures   = 0;
			free_all();
		endfunction

		function void free_all();
			free_map   = '1;
			free_total = slot_count;
		endfunction

		// A zero count is taken as one slot, and large counts saturate.
		function void write_count(logic [6:0] value);
			if (value == 7'd0) begin
				slot_count = 1;
			end else if (value > 7'd64) begin
				slot_count = 64;
			end else begin
				slot_count = value;
			end
			free_all();
		endfunction

		function void note_request(logic cmd, logic [5:0] slot_index);
			reply_t      r;
			bit          found;
			int unsigned i;
			r.granted = '0;
			found     = 1'b0;
			if (cmd == fsba_pkg::CMD_ALLOC) begin
				// Grant the lowest free slot among those in use.
				r.status = fsba_pkg::ST_EMPTY;
				for (i = 0; i < slot_count; i++) begin
					if (!found && free_map[i]) begin
						found       = 1'b1;
						free_map[i] = 1'b0;
						if (free_total > 0) free_total--;
						r.status  = fsba_pkg::ST_OK;
						r.granted = i[5:0];
					end
				end
			end else if (slot_index >= slot_count) begin
				r.status = fsba_pkg::ST_UNKNOWN;
			end else if (free_map[slot_index]) begin
				r.status = fsba_pkg::ST_ALREADY_FREE;
			end else begin
				free_map[slot_index] = 1'b1;
				if (free_total < slot_count) free_total++;
				r.status = fsba_pkg::ST_OK;
			end
			r.free_slots = free_total[6:0];
			awaited.push_back(r);
		endfunction

		function void check_reply(fsba_pkg::status_t status, logic [5:0] granted,
				logic [6:0] free_slots);
			reply_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected reply status=%0d slot=%0d free=%0d",
						$realtime, status, granted, free_slots);
				return;
			end
			want = awaited.pop_front();
			if (want.status !== status || want.granted !== granted
					|| want.free_slots !== free_slots) begin
				failures++;
				if (failures <= 10)
					$display({"%0t: reply mismatch: expected status=%0d slot=%0d free=%0d,",
						" got status=%0d slot=%0d free=%0d"},
						$realtime, want.status, want.granted, want.free_slots,
						status, granted, free_slots);
			end
		endfunction

		// A slot currently granted, searched from a random start, or -1.
		function int pick_used_slot();
			int unsigned start;
			int unsigned k;
			int unsigned s;
			start = $urandom_range(0, slot_count - 1);
			for (k = 0; k < slot_count; k++) begin
				s = (start + k) % slot_count;
				if (!free_map[s]) return s;
			end
			return -1;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // slot_index[5:0]
	logic [0:0]  s_tuser = '0;   // cmd[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // granted_slot[5:0], free_slots[12:6]
	logic [1:0]  m_tuser;        // status[1:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	int unsigned    send_gap_pct = 0;
	int unsigned    recv_stall_pct = 0;
	slot_pool_model pool;

	fixed_slot_buffer_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock with a 12 ns period.
	initial begin
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random according to the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check every reply item that leaves the block.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pool.check_reply(fsba_pkg::status_t'(m_tuser), m_tdata[5:0], m_tdata[12:6]);
	end

	// Offer one request item, with random idle cycles ahead of it.
	task automatic send_request(logic cmd, logic [5:0] slot_index);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, slot_index};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pool.note_request(cmd, slot_index);
	endtask

	// Stop sending and let every queued reply come back.
	task automatic drain_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pool.awaited.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write slot_count; only called while the block is idle.
	task automatic write_slot_count(logic [6:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pool.write_count(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly allocations and frees of granted slots, with some stray frees.
	task automatic random_request(int unsigned alloc_pct);
		int unsigned pick;
		int          used;
		pick = $urandom_range(0, 99);
		if (pick < alloc_pct) begin
			send_request(fsba_pkg::CMD_ALLOC, 6'($urandom));
		end else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
			used = pool.pick_used_slot();
			if (used < 0) send_request(fsba_pkg::CMD_FREE, 6'($urandom_range(0, 63)));
			else send_request(fsba_pkg::CMD_FREE, 6'(used));
		end else begin
			send_request(fsba_pkg::CMD_FREE, 6'($urandom_range(0, 63)));
		end
	endtask

	// Random phases: slot_count written (-1 picks one), allocate share, items.
	int phase_count[8] = '{127, 64, 1, 33, 2, -1, 96, 63};
	int phase_alloc[8] = '{90, 55, 50, 60, 50, 55, 85, 50};
	int phase_items[8] = '{100, 60, 40, 60, 40, 60, 80, 50};

	initial begin
		pool = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Pool of 64 straight after reset.
		send_request(fsba_pkg::CMD_ALLOC, 6'd0);
		send_request(fsba_pkg::CMD_FREE, 6'd0);
		send_request(fsba_pkg::CMD_FREE, 6'd0);
		send_request(fsba_pkg::CMD_FREE, 6'd63);
		send_request(fsba_pkg::CMD_ALLOC, 6'd63);
		drain_replies();

		// Three slots: fill, run empty, frees outside and inside the pool.
		write_slot_count(7'd3);
		repeat (4) send_request(fsba_pkg::CMD_ALLOC, 6'd0);
		send_request(fsba_pkg::CMD_FREE, 6'd1);
		send_request(fsba_pkg::CMD_FREE, 6'd1);
		send_request(fsba_pkg::CMD_FREE, 6'd3);
		send_request(fsba_pkg::CMD_FREE, 6'd63);
		send_request(fsba_pkg::CMD_ALLOC, 6'd0);
		drain_replies();

		// A zero count leaves a single slot.
		write_slot_count(7'd0);
		send_request(fsba_pkg::CMD_ALLOC, 6'd0);
		send_request(fsba_pkg::CMD_ALLOC, 6'd0);
		send_request(fsba_pkg::CMD_FREE, 6'd1);
		send_request(fsba_pkg::CMD_FREE, 6'd0);
		send_request(fsba_pkg::CMD_FREE, 6'd0);
		drain_replies();

		// Random phases with changing pool size and idling.
		for (int p = 0; p < 8; p++) begin
			if (phase_count[p] < 0) write_slot_count(7'($urandom_range(0, 127)));
			else write_slot_count(7'(phase_count[p]));
			case (p % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
				default: begin send_gap_pct = 8; recv_stall_pct = 8; end
			endcase
			for (int n = 0; n < phase_items[p]; n++) begin
				// Now and then hold off until the block has answered everything.
				if (n == phase_items[p] / 2 && (p % 2) == 1) drain_replies();
				random_request(phase_alloc[p]);
			end
			drain_replies();
		end

		if (pool.failures == 0) begin
			$display("fixed_slot_buffer_allocator regression: pass");
		end else begin
			$display("fixed_slot_buffer_allocator regression: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("fixed_slot_buffer_allocator regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
sv/fsba_pkg.sv
sv/fsba_ram.sv
sv/fixed_slot_buffer_allocator.sv
tb/testbench.sv
